FILE: rtl/core/kda_pkg.sv
package kda_pkg;

  localparam int SCAN_W     = 24;
  localparam int TIME_W     = 32;
  localparam int DELAY_W    = 16;
  localparam int STATUS_W   = 44;
  localparam int PHASE_W    = 2;
  // Keys that fit in the status word.
  localparam int STATUS_KEYS = STATUS_W / PHASE_W;

  localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd420;

  localparam int MAP_SIZE = 24;
  localparam logic [7:0] NO_KEY = 8'hFF;

  // Key number for each matrix position; NO_KEY marks a position without a key.
  localparam logic [7:0] POS_TO_KEY [MAP_SIZE] = '{
    8'd2,  8'd0,  8'd3,  8'd6,
    8'd8,  8'd1,  8'd9,  8'd5,
    8'd10, 8'd11, 8'd12, 8'd7,
    8'd13, 8'd14, 8'd15, 8'd4,
    8'd16, 8'd17, 8'd18, NO_KEY,
    8'd20, 8'd19, 8'd21, NO_KEY
  };

  typedef enum logic [PHASE_W-1:0] {
    PHASE_RELEASED = 2'd0,
    PHASE_PRESSED  = 2'd1,
    PHASE_REPEAT   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [SCAN_W-1:0]   debounced_bits;
    logic [STATUS_W-1:0] key_status;
  } result_t;

  // Matrix position that drives a key, or -1 when the map has none.
  function automatic int key_position(input int key);
    int pos;
    pos = -1;
    for (int i = MAP_SIZE - 1; i >= 0; i--) begin
      if (int'(POS_TO_KEY[i]) == key) begin
        pos = i;
      end
    end
    return pos;
  endfunction

endpackage

FILE: rtl/core/kda_if.sv
interface kda_in_if import kda_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SCAN_W-1:0] scan_bits;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, output scan_bits, output now_ms, input ready);
  modport sink   (input valid, input scan_bits, input now_ms, output ready);
endinterface

interface kda_out_if import kda_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SCAN_W-1:0]   debounced_bits;
  logic [STATUS_W-1:0] key_status;

  modport source (output valid, output debounced_bits, output key_status, input ready);
  modport sink   (input valid, input debounced_bits, input key_status, output ready);
endinterface

FILE: rtl/core/kda_history.sv
module kda_history #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [WIDTH-1:0] sample,
  output logic [WIDTH-1:0] down_next
);

  localparam int PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] history [DEPTH];
  logic [PTR_W-1:0] pointer;

  // The slot about to be overwritten is left out; the new sample takes its place.
  always_comb begin
    down_next = sample;
    for (int i = 0; i < DEPTH; i++) begin
      if (pointer != PTR_W'(i)) begin
        down_next = down_next | history[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pointer <= '0;
      for (int i = 0; i < DEPTH; i++) begin
        history[i] <= '0;
      end
    end else if (accept) begin
      history[pointer] <= sample;
      if (pointer == PTR_W'(DEPTH - 1)) begin
        pointer <= '0;
      end else begin
        pointer <= pointer + 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/kda_lane.sv
module kda_lane import kda_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                enable,
  input  logic                down,
  input  logic [TIME_W-1:0]   now_ms,
  input  logic [DELAY_W-1:0]  repeat_delay_ms,
  output phase_t              phase_next
);

  phase_t            phase;
  logic [TIME_W-1:0] stamp;
  logic [TIME_W-1:0] held;

  assign held = now_ms - stamp;

  always_comb begin
    phase_next = phase;
    if (enable) begin
      if (!down) begin
        phase_next = PHASE_RELEASED;
      end else begin
        unique case (phase)
          PHASE_PRESSED: begin
            if (held > TIME_W'(repeat_delay_ms)) begin
              phase_next = PHASE_REPEAT;
            end
          end
          default: phase_next = PHASE_PRESSED;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PHASE_RELEASED;
      stamp <= '0;
    end else begin
      phase <= phase_next;
      if (enable && down && phase == PHASE_RELEASED) begin
        stamp <= now_ms;
      end
    end
  end

endmodule

FILE: rtl/core/kda_out_buffer.sv
module kda_out_buffer import kda_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    has_room,
  kda_out_if.source result
);

  result_t    slot [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       pop;

  assign has_room = (count != 2'd2);
  assign pop      = result.valid && result.ready;

  assign result.valid          = (count != 2'd0);
  assign result.debounced_bits = slot[rptr].debounced_bits;
  assign result.key_status     = slot[rptr].key_status;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/core/keypad_debounce_autorepeat_unit.sv
// Keypad debounce and auto-repeat. Every beat on the scan channel carries one
// full matrix sample and the millisecond time; every such beat yields exactly one
// result beat with the debounced matrix and the two-bit state of every key
// (0 released, 1 pressed, 2 repeat). It takes one scan per clock cycle while its
// two-entry output queue has room. Each result is queued as its scan is taken and
// can leave in the cycle after, so a stalled sink holds back the scan channel
// only once two results are waiting. All key lanes update in the cycle a scan is
// taken: one 32-bit subtract and compare each. The user must write the repeat
// delay via cfg_wr_en and cfg_wr_data while idle; the block does not check it.
module keypad_debounce_autorepeat_unit import kda_pkg::*; #(
  parameter int HISTORY_DEPTH  = 4,
  parameter int MATRIX_COLUMNS = 4,
  parameter int MATRIX_ROWS    = 6,
  parameter int KEY_COUNT      = 22
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [DELAY_W-1:0] cfg_wr_data,
  kda_in_if.sink             scan,
  kda_out_if.source          result
);

  // Positions beyond the scan word never see a set bit, so they are not stored.
  localparam int POSITIONS = MATRIX_COLUMNS * MATRIX_ROWS;
  localparam int POS_W     = (POSITIONS < SCAN_W) ? POSITIONS : SCAN_W;
  // Only keys that appear in the status word need a lane.
  localparam int LANES     = (KEY_COUNT < STATUS_KEYS) ? KEY_COUNT : STATUS_KEYS;

  logic [DELAY_W-1:0] repeat_delay_ms;
  logic               accept;
  logic               has_room;
  logic [POS_W-1:0]   down_next;
  phase_t             phase_next [LANES];
  result_t            push_data;

  assign scan.ready = has_room;
  assign accept     = scan.valid && has_room;

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_delay_ms <= DELAY_RESET;
    end else if (cfg_wr_en) begin
      repeat_delay_ms <= cfg_wr_data;
    end
  end

  // The history ring gives the OR of the new scan and the older samples that
  // survive this write, which is the debounced matrix after the beat.
  kda_history #(
    .DEPTH (HISTORY_DEPTH),
    .WIDTH (POS_W)
  ) u_history (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .sample    (scan.scan_bits[POS_W-1:0]),
    .down_next (down_next)
  );

  // One lane per key. A key whose map position lies outside the matrix is never
  // updated and stays released.
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    localparam int  POS     = key_position(k);
    localparam bit  HAS_POS = (POS >= 0) && (POS < POS_W);
    localparam int  POS_IDX = HAS_POS ? POS : 0;

    kda_lane u_lane (
      .clk             (clk),
      .rst             (rst),
      .enable          (accept && HAS_POS),
      .down            (down_next[POS_IDX]),
      .now_ms          (scan.now_ms),
      .repeat_delay_ms (repeat_delay_ms),
      .phase_next      (phase_next[k])
    );
  end

  // Merge: the lanes' new states are packed with the debounced matrix and queued
  // in the same cycle as the scan is taken. The registered lane states are kept
  // only for the update itself.
  always_comb begin
    push_data.debounced_bits = SCAN_W'(down_next);
    push_data.key_status     = '0;
    for (int k = 0; k < LANES; k++) begin
      push_data.key_status[PHASE_W*k +: PHASE_W] = phase_next[k];
    end
  end

  kda_out_buffer u_out_buffer (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (push_data),
    .has_room  (has_room),
    .result    (result)
  );

endmodule

FILE: sim/kda_result_checker.sv
module kda_result_checker import kda_pkg::*; #(
  parameter int HISTORY = 4,
  parameter int KEYS    = 22
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [DELAY_W-1:0] cfg_wr_data,
  kda_in_if                  scan_mon,
  kda_out_if                 result_mon,
  output int                 fail_count,
  output int                 queued_results
);

  logic [SCAN_W-1:0]  scan_ring [HISTORY];
  int                 ring_slot;
  phase_t             key_phase [KEYS];
  logic [TIME_W-1:0]  press_stamp [KEYS];
  logic [DELAY_W-1:0] repeat_delay;
  result_t            pending_results [$];
  int                 mismatches;

  // Folds one scan into the history and steps every mapped key.
  function automatic result_t debounce_scan(input logic [SCAN_W-1:0] bits,
                                            input logic [TIME_W-1:0] now);
    logic [SCAN_W-1:0] held;
    logic [TIME_W-1:0] elapsed;
    int                key;
    result_t           r;
    scan_ring[ring_slot] = bits;
    ring_slot = (ring_slot + 1) % HISTORY;
    held = '0;
    for (int i = 0; i < HISTORY; i++) held |= scan_ring[i];
    for (int p = 0; p < SCAN_W; p++) begin
      if (POS_TO_KEY[p] != NO_KEY && int'(POS_TO_KEY[p]) < KEYS) begin
        key = int'(POS_TO_KEY[p]);
        if (!held[p]) begin
          key_phase[key] = PHASE_RELEASED;
        end else if (key_phase[key] == PHASE_PRESSED) begin
          elapsed = now - press_stamp[key];
          if (elapsed > TIME_W'(repeat_delay)) key_phase[key] = PHASE_REPEAT;
        end else begin
          if (key_phase[key] == PHASE_RELEASED) press_stamp[key] = now;
          key_phase[key] = PHASE_PRESSED;
        end
      end
    end
    r.debounced_bits = held;
    r.key_status     = '0;
    for (int k = 0; k < KEYS; k++) r.key_status[2*k +: 2] = key_phase[k];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (rst) begin
      for (int i = 0; i < HISTORY; i++) scan_ring[i] = '0;
      for (int k = 0; k < KEYS; k++) begin
        key_phase[k]   = PHASE_RELEASED;
        press_stamp[k] = '0;
      end
      ring_slot    = 0;
      repeat_delay = DELAY_RESET;
      pending_results.delete();
    end else begin
      if (cfg_wr_en) repeat_delay = cfg_wr_data;
      // A result never leaves in the cycle its scan is taken, so the check
      // comes before the new prediction is queued.
      if (result_mon.valid && result_mon.ready) begin
        got.debounced_bits = result_mon.debounced_bits;
        got.key_status     = result_mon.key_status;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got bits %h status %h",
                   $time, got.debounced_bits, got.key_status);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (got.debounced_bits !== want.debounced_bits) begin
            $display("%0t: debounced_bits expected %h, got %h",
                     $time, want.debounced_bits, got.debounced_bits);
            mismatches++;
          end
          if (got.key_status !== want.key_status) begin
            $display("%0t: key_status expected %h, got %h",
                     $time, want.key_status, got.key_status);
            mismatches++;
          end
        end
      end
      if (scan_mon.valid && scan_mon.ready) begin
        pending_results.push_back(debounce_scan(scan_mon.scan_bits, scan_mon.now_ms));
      end
    end
    fail_count     <= mismatches;
    queued_results <= pending_results.size();
  end

endmodule

FILE: sim/tb_keypad_debounce_autorepeat_unit.sv
// Test bench for the keypad debounce and auto-repeat unit. This top level only
// produces scan beats, throttles the result channel and gives the verdict; the
// checker instantiated beside the block watches both channels and the
// configuration port, predicts every result beat and counts the mismatches.
module tb_keypad_debounce_autorepeat_unit;
  import kda_pkg::*;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_wr_en;
  logic [DELAY_W-1:0] cfg_wr_data;
  int                 fail_count;
  int                 queued_results;

  kda_in_if  scan_if ();
  kda_out_if result_if ();

  // The millisecond time carried by the scans of a key session; it advances in
  // steps scaled to the repeat delay so that held keys actually reach repeat.
  logic [TIME_W-1:0]  clock_ms;
  logic [DELAY_W-1:0] active_delay;
  int                 scans_sent;
  int                 results_taken;
  bit                 sender_steady;
  bit                 receiver_steady;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  keypad_debounce_autorepeat_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .scan        (scan_if),
    .result      (result_if)
  );

  kda_result_checker result_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .scan_mon       (scan_if),
    .result_mon     (result_if),
    .fail_count     (fail_count),
    .queued_results (queued_results)
  );

  // Offers one scan beat and returns at the clock edge at which it is taken.
  // Valid is left high on return, so a following beat with no gap keeps it
  // high rather than dropping it and raising it again in the same step.
  task automatic send_scan(input logic [SCAN_W-1:0] bits, input logic [TIME_W-1:0] stamp);
    int gap;
    // Every forty beats the sender decides afresh whether to run flat out,
    // which gives stretches without any idle cycles between the gappy ones.
    if (scans_sent % 40 == 0) sender_steady = ($urandom_range(0, 3) == 0);
    gap = sender_steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      scan_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    scan_if.valid     <= 1'b1;
    scan_if.scan_bits <= bits;
    scan_if.now_ms    <= stamp;
    do @(posedge clk); while (!scan_if.ready);
    scans_sent++;
  endtask

  // Stops offering scans and waits until every predicted result has been
  // seen. Every scan yields a result, so this empties the block.
  task automatic drain_results();
    scan_if.valid <= 1'b0;
    do @(posedge clk); while (queued_results != 0);
    repeat (4) @(posedge clk);
  endtask

  // The repeat delay may only change while the block is idle.
  task automatic write_repeat_delay(input logic [DELAY_W-1:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    active_delay = value;
  endtask

  // Mostly small steps of up to a third of the delay plus eight, now and then
  // a jump to an arbitrary point so the time wraps and every bit of it moves.
  function automatic logic [TIME_W-1:0] time_step();
    if ($urandom_range(0, 15) == 0) return $urandom();
    return $urandom_range(0, int'(active_delay) / 3 + 8);
  endfunction

  // Presses a key set at a given time and walks it across the repeat boundary:
  // an elapsed time equal to the delay keeps the key pressed, one more
  // millisecond gives repeat, and the next scan goes back to pressed. Four
  // empty scans then flush the history and release everything.
  task automatic hold_across_delay(input logic [SCAN_W-1:0] bits,
                                   input logic [TIME_W-1:0] start);
    send_scan(bits, start);
    send_scan(bits, start + active_delay);
    send_scan(bits, start + active_delay + 1);
    send_scan(bits, start + active_delay + 2);
    repeat (4) send_scan('0, start + active_delay + 3);
  endtask

  // A well-formed press: a few keys (occasionally a random crowd of them) are
  // held for a while with contact bounce and the odd stray bit, then let go
  // for long enough that the debounce history empties.
  task automatic key_session();
    logic [SCAN_W-1:0] held_keys;
    logic [SCAN_W-1:0] bits;
    held_keys = '0;
    if ($urandom_range(0, 7) == 0) begin
      held_keys = SCAN_W'($urandom());
    end else begin
      repeat ($urandom_range(1, 4)) held_keys[$urandom_range(0, SCAN_W - 1)] = 1'b1;
    end
    repeat ($urandom_range(2, 30)) begin
      bits = held_keys;
      if ($urandom_range(0, 3) == 0) bits[$urandom_range(0, SCAN_W - 1)] = 1'b0;
      if ($urandom_range(0, 7) == 0) bits[$urandom_range(0, SCAN_W - 1)] = 1'b1;
      clock_ms += time_step();
      send_scan(bits, clock_ms);
    end
    repeat ($urandom_range(4, 7)) begin
      clock_ms += time_step();
      send_scan('0, clock_ms);
    end
  endtask

  // Random traffic: key sessions, each now and then preceded by a burst of
  // pure noise with arbitrary bits and times. Ending on a session leaves the
  // history clear for whatever follows.
  task automatic random_phase(input int count);
    int target;
    target = scans_sent + count;
    while (scans_sent < target) begin
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 5)) send_scan(SCAN_W'($urandom()), $urandom());
      end
      key_session();
    end
  endtask

  initial begin : stimulus
    rst               <= 1'b1;
    cfg_wr_en         <= 1'b0;
    cfg_wr_data       <= '0;
    scan_if.valid     <= 1'b0;
    scan_if.scan_bits <= '0;
    scan_if.now_ms    <= '0;
    active_delay = DELAY_RESET;
    scans_sent   = 0;
    clock_ms     = $urandom();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset delay. The full matrix is pressed just
    // before the time wraps, so the elapsed time is taken across the wrap.
    send_scan('0, '0);
    hold_across_delay('1, 32'hFFFF_FF00);
    // Only the two positions without a key: they show in the debounced bits
    // and must leave every key released.
    send_scan(24'h880000, 32'hFFFF_FFFF);
    send_scan(24'h800000, 32'h0000_0001);
    send_scan(24'h000001, 32'h8000_0000);
    send_scan(24'h555555, 32'h5555_5555);
    send_scan(24'hAAAAAA, 32'hAAAA_AAAA);
    random_phase(355);

    // Zero delay: any elapsed time at all gives repeat.
    write_repeat_delay('0);
    hold_across_delay(24'h000002, $urandom());
    random_phase(355);

    // Largest delay.
    write_repeat_delay('1);
    hold_across_delay(SCAN_W'($urandom()) | 24'h000001, $urandom());
    random_phase(355);

    write_repeat_delay(DELAY_W'($urandom_range(1, 2000)));
    random_phase(355);

    write_repeat_delay(DELAY_W'($urandom()));
    random_phase(355);

    drain_results();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Result side. Ready is withheld for a random number of cycles before each
  // beat, with stretches of constant readiness, and now and then for a long
  // hold-off so that the output queue fills and the block stalls its input.
  initial begin : sink_side
    int stall;
    result_if.ready <= 1'b0;
    results_taken = 0;
    do @(posedge clk); while (rst);
    forever begin
      if (results_taken % 50 == 0) receiver_steady = ($urandom_range(0, 3) == 0);
      if (results_taken % 600 == 250) begin
        stall = 80;
      end else begin
        stall = receiver_steady ? 0 : $urandom_range(0, 11);
      end
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk); while (!result_if.valid);
      results_taken++;
    end
  end

  // A run that has not finished by this point in time counts as a failure.
  initial begin : watchdog
    #8_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/kda_pkg.sv
rtl/core/kda_if.sv
rtl/core/kda_history.sv
rtl/core/kda_lane.sv
rtl/core/kda_out_buffer.sv
rtl/core/keypad_debounce_autorepeat_unit.sv
sim/kda_result_checker.sv
sim/tb_keypad_debounce_autorepeat_unit.sv
